/* sv/phbf_pkg.sv */
`default_nettype none

package phbf_pkg;

  // Filter geometry and palette size.
  localparam int unsigned Radius       = 1;
  localparam int unsigned CenterWeight = 2;
  localparam int unsigned PaletteDepth = 16;

  localparam int unsigned Win      = 2 * Radius + 1;
  localparam int unsigned FillW    = $clog2(Win + 1);
  localparam int unsigned PosW     = $clog2(Radius + 1);
  localparam int unsigned PalAddrW = $clog2(PaletteDepth);

  localparam int unsigned IdxW   = 4;
  localparam int unsigned ColorW = 12;
  localparam int unsigned ChanW  = 8;

  // Entries in the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Operation codes of an input transaction.
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_FILTER_ENABLE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SCANLINE_ENABLE = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [IdxW-1:0] pal_index;
    logic [ColorW-1:0] palette_color;
    logic            row_even;
    logic            line_last;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             line_end;
  } out_item_t;

  typedef struct packed {
    logic filter_enable;
    logic scanline_enable;
  } cfg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic              is_write;
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] color;
    logic              row;
    logic              last;
    logic              emit_en;
    logic [PosW-1:0]   start_pos;
    logic [FillW-1:0]  fill;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/palette_horizontal_blur_filter_unit.sv */
// Palette lookup with a horizontal weighted box blur.
// Input channel (in_valid_i / in_ready_o / in_item_i): each transaction is
// either a palette write, which stores a 12-bit colour, or a pixel that
// carries a palette index in raster order. Output channel (out_valid_o /
// out_ready_i / out_item_o) carries one 8-bit RGB pixel per transaction.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
// cfg_data_i) sets the filter and scanline enables and is always ready.
// A front stage classifies each transaction and pushes it into a two-entry
// queue; the back stage performs palette updates and window arithmetic.
// A pixel passes through a queue entry and the back's window registers
// before its result reaches the output register. The back takes a palette
// write or a pixel from the queue, then emits the pixel's results one at a
// time while the output register is free; a mid-line pixel yields at most
// one, a line-end pixel up to radius + 1. Results lag by the radius.
// Reset clears the palette, the pixel window, the queue and both enables.
// When the receiver stalls, the output register holds its transaction, the
// back stage waits, the queue fills and in_ready_o drops.
`default_nettype none

module palette_horizontal_blur_filter_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  phbf_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output phbf_pkg::out_item_t   out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [phbf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                  cfg_data_i
);
  import phbf_pkg::*;

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  // Configuration writes are registered; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FILTER_ENABLE: begin
          cfg_q.filter_enable <= cfg_data_i;
        end
        REG_SCANLINE_ENABLE: begin
          cfg_q.scanline_enable <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // The front tracks how many pixels of the line are held, so each
  // transaction enters the queue already knowing how many results it yields.
  phbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  phbf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  // The back keeps palette and window in order with the pixel stream, so
  // a palette write affects every pixel not yet output.
  phbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* sv/phbf_front.sv */
`default_nettype none

module phbf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  phbf_pkg::in_item_t in_item_i,
  output logic               in_ready_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output phbf_pkg::cmd_t     q_cmd_o
);
  import phbf_pkg::*;

  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] fill_inc;

  // Pixels of the current line held in the back's window, saturating.
  assign fill_inc = (fill_q == FillW'(Win)) ? fill_q : fill_q + FillW'(1);

  always_comb begin
    in_ready_o        = !q_full_i;
    q_push_o          = in_valid_i && !q_full_i;

    q_cmd_o.is_write  = (in_item_i.operation == OP_PAL_WRITE);
    q_cmd_o.idx       = in_item_i.pal_index;
    q_cmd_o.color     = in_item_i.palette_color;
    q_cmd_o.row       = in_item_i.row_even;
    q_cmd_o.last      = in_item_i.line_last;
    q_cmd_o.fill      = fill_inc;

    if (in_item_i.line_last) begin
      // The last pixel flushes every pending pixel, oldest first.
      q_cmd_o.emit_en = 1'b1;
      if (fill_inc > FillW'(Radius)) begin
        q_cmd_o.start_pos = PosW'(Radius);
      end else begin
        q_cmd_o.start_pos = PosW'(fill_inc - FillW'(1));
      end
    end else begin
      q_cmd_o.emit_en   = (fill_inc > FillW'(Radius));
      q_cmd_o.start_pos = PosW'(Radius);
    end

    fill_d = fill_q;
    if (q_push_o && (in_item_i.operation == OP_PIXEL)) begin
      fill_d = in_item_i.line_last ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

/* sv/phbf_fifo.sv */
`default_nettype none

module phbf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  phbf_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output phbf_pkg::cmd_t pop_cmd_o
);
  import phbf_pkg::*;

  localparam int unsigned PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  cmd_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o    = (count_q == CountW'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/phbf_back.sv */
`default_nettype none

module phbf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phbf_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  phbf_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phbf_pkg::out_item_t out_item_o
);
  import phbf_pkg::*;

  localparam int unsigned MaxWeight  = CenterWeight + 2 * Radius;
  localparam int unsigned MaxCnt     = MaxWeight + 1;
  localparam int unsigned CntW       = $clog2(MaxCnt + 1);
  localparam int unsigned NibSumW    = $clog2(15 * MaxWeight + 1);
  localparam int unsigned ScaledW    = $clog2(255 * MaxWeight + 1);
  localparam int unsigned RecipK     = 20;
  localparam int unsigned RecipW     = RecipK + 1;
  localparam int unsigned RecipDepth = 1 << CntW;
  localparam int unsigned ProdW      = ScaledW + RecipW;
  localparam int unsigned NibExpand  = 17;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_q, state_d;
  logic [PosW-1:0]   pos_q;
  logic              last_q;
  logic [FillW-1:0]  fill_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [ColorW-1:0] pal_q     [PaletteDepth];
  logic [IdxW-1:0]   win_idx_q [Win];
  logic [ColorW-1:0] win_col_q [Win];
  logic              win_row_q [Win];

  logic [RecipW-1:0] recip_tab [RecipDepth];

  logic              out_free, emit;
  logic              idx_in_range;
  logic [PalAddrW-1:0] pal_addr;
  logic [ColorW-1:0] lookup_col;

  logic [NibSumW-1:0] nib_r, nib_g, nib_b, w;
  logic [CntW-1:0]    cnt;
  logic [ColorW-1:0]  cen_col;
  logic               cen_row;
  logic [ScaledW-1:0] sc_r, sc_g, sc_b;
  logic [ProdW-1:0]   prod_r, prod_g, prod_b;
  logic [RecipW-1:0]  recip_sel;
  out_item_t          emit_item;

  // Ceiling reciprocals of the divisor; exact truncating quotient for all sums.
  for (genvar g = 0; g < RecipDepth; g++) begin : g_recip
    if (g == 0) begin : g_zero
      assign recip_tab[g] = RecipW'(1 << RecipK);
    end else begin : g_div
      localparam int unsigned RecipVal = ((1 << RecipK) + g - 1) / g;
      assign recip_tab[g] = RecipW'(RecipVal);
    end
  end

  assign idx_in_range = (int'(q_cmd_i.idx) < PaletteDepth);
  assign pal_addr     = PalAddrW'(q_cmd_i.idx);
  assign lookup_col   = idx_in_range ? pal_q[pal_addr] : '0;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
    emit     = (state_q == ST_EMIT) && out_free;

    state_d = state_q;
    if (q_pop_o && !q_cmd_i.is_write && q_cmd_i.emit_en) begin
      state_d = ST_EMIT;
    end
    if (emit && (!last_q || (pos_q == '0))) begin
      state_d = ST_IDLE;
    end
  end

  // Weighted window sums for the pixel at position pos_q (0 is newest).
  always_comb begin
    nib_r   = '0;
    nib_g   = '0;
    nib_b   = '0;
    cnt     = '0;
    cen_col = '0;
    cen_row = 1'b0;
    w       = '0;
    for (int k = 0; k < Win; k++) begin
      w = (k == int'(pos_q)) ? NibSumW'(CenterWeight) : NibSumW'(1);
      if (k == int'(pos_q)) begin
        cen_col = win_col_q[k];
        cen_row = win_row_q[k];
      end
      if ((k < int'(fill_q)) && (k <= int'(pos_q) + Radius) &&
          (k + Radius >= int'(pos_q))) begin
        nib_r = nib_r + NibSumW'(win_col_q[k][7:4] * w);
        nib_g = nib_g + NibSumW'(win_col_q[k][11:8] * w);
        nib_b = nib_b + NibSumW'(win_col_q[k][3:0] * w);
        cnt   = cnt + CntW'(w);
      end
    end
    if (cfg_i.scanline_enable && cen_row) begin
      cnt = cnt + CntW'(1);
    end

    recip_sel = recip_tab[cnt];
    sc_r      = ScaledW'(nib_r * NibExpand);
    sc_g      = ScaledW'(nib_g * NibExpand);
    sc_b      = ScaledW'(nib_b * NibExpand);
    prod_r    = ProdW'(sc_r) * ProdW'(recip_sel);
    prod_g    = ProdW'(sc_g) * ProdW'(recip_sel);
    prod_b    = ProdW'(sc_b) * ProdW'(recip_sel);

    if (cfg_i.filter_enable) begin
      emit_item.red   = prod_r[RecipK +: ChanW];
      emit_item.green = prod_g[RecipK +: ChanW];
      emit_item.blue  = prod_b[RecipK +: ChanW];
    end else begin
      emit_item.red   = {cen_col[7:4], cen_col[7:4]};
      emit_item.green = {cen_col[11:8], cen_col[11:8]};
      emit_item.blue  = {cen_col[3:0], cen_col[3:0]};
    end
    emit_item.line_end = last_q && (pos_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      last_q      <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < PaletteDepth; k++) begin
        pal_q[k] <= '0;
      end
      for (int k = 0; k < Win; k++) begin
        win_idx_q[k] <= '0;
        win_col_q[k] <= '0;
        win_row_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        if (q_cmd_i.is_write) begin
          if (idx_in_range) begin
            pal_q[pal_addr] <= q_cmd_i.color;
            // Pixels still waiting in the window see the new colour.
            for (int k = 0; k < Win; k++) begin
              if (win_idx_q[k] == q_cmd_i.idx) begin
                win_col_q[k] <= q_cmd_i.color;
              end
            end
          end
        end else begin
          for (int k = Win - 1; k > 0; k--) begin
            win_idx_q[k] <= win_idx_q[k-1];
            win_col_q[k] <= win_col_q[k-1];
            win_row_q[k] <= win_row_q[k-1];
          end
          win_idx_q[0] <= q_cmd_i.idx;
          win_col_q[0] <= lookup_col;
          win_row_q[0] <= q_cmd_i.row;
          fill_q       <= q_cmd_i.fill;
          pos_q        <= q_cmd_i.start_pos;
          last_q       <= q_cmd_i.last;
        end
      end else if (emit) begin
        pos_q <= pos_q - PosW'(1);
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* sv/phbf_checker.sv */
`default_nettype none

module phbf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input phbf_pkg::out_item_t out_item_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("output payload changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // After reset the queue is empty, so input is taken.
  assert property (@(posedge clk_i) !rst_ni |=> in_ready_o)
    else $error("input not ready after reset");

endmodule

bind palette_horizontal_blur_filter_unit phbf_checker u_phbf_checker (.*);

`default_nettype wire
